// ===== hw/rtl/rpn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the reverse Polish calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_STEPS   = 48;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_SUB     = 3'd2,
    KIND_MUL     = 3'd3,
    KIND_DIV     = 3'd4,
    KIND_REM     = 3'd5,
    KIND_PRINT   = 3'd6,
    KIND_UNKNOWN = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD = 2'd0,
    SHIFT_PUSH = 2'd1,
    SHIFT_POP  = 2'd2
  } shift_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POP_B, ST_POP_A, ST_EXEC, ST_MUL, ST_DIV, ST_DIV_DONE, ST_PUSH,
    ST_OUT
  } state_t;

  typedef struct packed {
    shift_op_t          op;
    logic signed [31:0] push_data;
  } shift_ctl_t;

endpackage

// ===== hw/rtl/rpn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_cmd_if / rpn_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface rpn_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] operand_value;
  modport source (output valid, kind, operand_value, input ready);
  modport sink   (input valid, kind, operand_value, output ready);
endinterface

interface rpn_res_if;
  logic               valid;
  logic               ready;
  logic               printed;
  logic signed [31:0] result_value;
  logic               underflow;
  logic               stack_full;
  logic               zero_divisor;
  logic               unknown_command;
  logic               saturated;
  modport source (output valid, printed, result_value, underflow, stack_full,
                  zero_divisor, unknown_command, saturated, input ready);
  modport sink   (input valid, printed, result_value, underflow, stack_full,
                  zero_divisor, unknown_command, saturated, output ready);
endinterface

// ===== hw/rtl/rpn_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_cell
// One stack entry: loads from the cell above on push, from below on pop.
// ----------------------------------------------------------------------------
module rpn_cell (
  input  logic               clk,
  input  rpn_pkg::shift_op_t op,
  input  logic signed [31:0] from_up,
  input  logic signed [31:0] from_down,
  output logic signed [31:0] value
);

  always_ff @(posedge clk) begin
    case (op)
      rpn_pkg::SHIFT_PUSH: value <= from_up;
      rpn_pkg::SHIFT_POP:  value <= from_down;
      default:             value <= value;
    endcase
  end

endmodule

// ===== hw/rtl/rpn_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack
// Shift-register stack built as a row of cells; cell 0 is the top.
// ----------------------------------------------------------------------------
module rpn_stack (
  input  logic                clk,
  input  rpn_pkg::shift_ctl_t ctl,
  output logic signed [31:0]  top
);

  localparam int N = rpn_pkg::STACK_DEPTH;

  logic signed [31:0] cells [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [31:0] up;
    logic signed [31:0] down;
    if (i == 0) begin : g_top
      assign up = ctl.push_data;
    end else begin : g_mid
      assign up = cells[i-1];
    end
    if (i == N - 1) begin : g_bot
      assign down = 32'sd0;
    end else begin : g_in
      assign down = cells[i+1];
    end
    rpn_cell u_cell (
      .clk      (clk),
      .op       (ctl.op),
      .from_up  (up),
      .from_down(down),
      .value    (cells[i])
    );
  end

  assign top = cells[0];

endmodule

// ===== hw/rtl/rpn_stack_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish calculator on signed Q16.16 values over a cell-chain stack.
//
// Commands arrive on cmd (kind, operand_value). Each command gives exactly one
// result transfer on res with the printed value and status flags. One command
// is handled at a time. Unknown goes straight to the result; push goes to the
// push step; print pops one entry; add and sub pop two, sum and push; mul also
// forms one 32x32 product, registered. Div and remainder pop two and run the
// divider, or stop after the first pop on a zero divisor. A radix-2 restoring
// divider retires one quotient bit per cycle over a 48-bit dividend. The next
// command is taken in the cycle after the result transfers.
// The stack is a row of 128 shift cells, top in cell 0; one push or pop moves
// every cell at once.
// Reset clears the entry count and returns to idle; cell contents are left
// as they are, since only entries below the count are ever read. When the
// receiver stalls the result is held in the output register, and the next
// command is not taken until it transfers.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
  input logic      clk,
  input logic      rst,
  rpn_cmd_if.sink  cmd,
  rpn_res_if.source res
);

  localparam int CW = rpn_pkg::CNT_W;
  localparam int SW = rpn_pkg::STEP_W;
  localparam logic [CW-1:0] DEPTH = CW'(rpn_pkg::STACK_DEPTH);
  localparam logic [SW-1:0] STEPS = SW'(rpn_pkg::DIV_STEPS);

  rpn_pkg::state_t     state, state_next;
  rpn_pkg::shift_ctl_t ctl;
  logic signed [31:0]  top;
  logic [CW-1:0]       count, count_next;
  rpn_pkg::kind_t      kind;
  logic signed [31:0]  a, b;
  logic signed [31:0]  a_next, b_next;
  logic signed [31:0]  push_val, push_val_next;
  logic                f_under, f_full, f_sat, f_zdiv;
  logic                f_under_next, f_full_next, f_sat_next, f_zdiv_next;
  logic [63:0]         prod;
  logic [47:0]         quo;
  logic [32:0]         rem;
  logic [31:0]         dvs;
  logic [SW-1:0]       step;
  logic                neg;

  rpn_stack u_stack (.clk(clk), .ctl(ctl), .top(top));

  assign cmd.ready = (state == rpn_pkg::ST_IDLE);

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [32:0] sat_mag(input logic [47:0] q, input logic n,
                                          output logic s);
    logic [48:0] lim;
    lim = n ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
    s = ({1'b0, q} > lim);
    sat_mag = s ? lim[32:0] : q[32:0];
  endfunction

  logic [32:0] rem_sh;
  logic [32:0] rem_try;
  assign rem_sh  = {rem[31:0], quo[47]};
  assign rem_try = rem_sh - {1'b0, dvs};

  logic [32:0] sm;
  logic        ss;
  logic [47:0] sm_in;
  logic signed [32:0] sum;

  always_comb begin
    state_next    = state;
    count_next    = count;
    a_next        = a;
    b_next        = b;
    push_val_next = push_val;
    f_under_next  = f_under;
    f_full_next   = f_full;
    f_sat_next    = f_sat;
    f_zdiv_next   = f_zdiv;
    ctl.op        = rpn_pkg::SHIFT_HOLD;
    ctl.push_data = push_val;
    sm_in         = (state == rpn_pkg::ST_MUL) ? prod[63:16] : quo;
    {sm, ss}      = '0;
    sm            = sat_mag(sm_in, neg, ss);
    sum           = (kind == rpn_pkg::KIND_ADD) ? 33'(a) + 33'(b) : 33'(a) - 33'(b);
    unique case (state)
      rpn_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          f_under_next = 1'b0;
          f_full_next  = 1'b0;
          f_sat_next   = 1'b0;
          f_zdiv_next  = 1'b0;
          push_val_next = cmd.operand_value;
          unique case (rpn_pkg::kind_t'(cmd.kind))
            rpn_pkg::KIND_PUSH:    state_next = rpn_pkg::ST_PUSH;
            rpn_pkg::KIND_UNKNOWN: state_next = rpn_pkg::ST_OUT;
            default:               state_next = rpn_pkg::ST_POP_B;
          endcase
        end
      end
      rpn_pkg::ST_POP_B: begin
        if (count != '0) begin
          b_next     = top;
          ctl.op     = rpn_pkg::SHIFT_POP;
          count_next = count - 1'b1;
        end else begin
          b_next       = '0;
          f_under_next = 1'b1;
        end
        if (kind == rpn_pkg::KIND_PRINT) begin
          state_next = rpn_pkg::ST_OUT;
        end else if ((kind == rpn_pkg::KIND_DIV || kind == rpn_pkg::KIND_REM) &&
                     ((count == '0) || (top == 32'sd0))) begin
          f_zdiv_next = 1'b1;
          state_next  = rpn_pkg::ST_OUT;
        end else begin
          state_next = rpn_pkg::ST_POP_A;
        end
      end
      rpn_pkg::ST_POP_A: begin
        if (count != '0) begin
          a_next     = top;
          ctl.op     = rpn_pkg::SHIFT_POP;
          count_next = count - 1'b1;
        end else begin
          a_next       = '0;
          f_under_next = 1'b1;
        end
        state_next = rpn_pkg::ST_EXEC;
      end
      rpn_pkg::ST_EXEC: begin
        unique case (kind)
          rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB: begin
            if (sum > 33'sh0_7FFF_FFFF) begin
              push_val_next = 32'sh7FFF_FFFF;
              f_sat_next    = 1'b1;
            end else if (sum < -33'sh0_8000_0000) begin
              push_val_next = 32'sh8000_0000;
              f_sat_next    = 1'b1;
            end else begin
              push_val_next = sum[31:0];
            end
            state_next = rpn_pkg::ST_PUSH;
          end
          rpn_pkg::KIND_MUL: state_next = rpn_pkg::ST_MUL;
          default:           state_next = rpn_pkg::ST_DIV;
        endcase
      end
      rpn_pkg::ST_MUL, rpn_pkg::ST_DIV_DONE: begin
        if (kind == rpn_pkg::KIND_REM) begin
          push_val_next = a[31] ? 32'(-rem[31:0]) : rem[31:0];
        end else begin
          push_val_next = neg ? 32'(-sm) : sm[31:0];
          f_sat_next    = ss;
        end
        state_next = rpn_pkg::ST_PUSH;
      end
      rpn_pkg::ST_DIV: begin
        if (step == STEPS - 1'b1) state_next = rpn_pkg::ST_DIV_DONE;
      end
      rpn_pkg::ST_PUSH: begin
        if (count < DEPTH) begin
          ctl.op     = rpn_pkg::SHIFT_PUSH;
          count_next = count + 1'b1;
        end else begin
          f_full_next = 1'b1;
        end
        state_next = rpn_pkg::ST_OUT;
      end
      rpn_pkg::ST_OUT: begin
        if (res.ready) state_next = rpn_pkg::ST_IDLE;
      end
      default: state_next = rpn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    a        <= a_next;
    b        <= b_next;
    push_val <= push_val_next;
    f_under  <= f_under_next;
    f_full   <= f_full_next;
    f_sat    <= f_sat_next;
    f_zdiv   <= f_zdiv_next;
    if (state == rpn_pkg::ST_IDLE && cmd.valid) begin
      kind <= rpn_pkg::kind_t'(cmd.kind);
    end
    if (state == rpn_pkg::ST_EXEC) begin
      prod <= 64'(mag32(a)) * 64'(mag32(b));
      neg  <= a[31] ^ b[31];
      quo  <= (kind == rpn_pkg::KIND_DIV) ? {mag32(a), 16'h0} : {16'h0, mag32(a)};
      dvs  <= mag32(b);
      rem  <= '0;
      step <= '0;
    end else if (state == rpn_pkg::ST_DIV) begin
      step <= step + 1'b1;
      if (!rem_try[32]) begin
        rem <= rem_try;
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign res.valid           = (state == rpn_pkg::ST_OUT);
  assign res.printed         = (kind == rpn_pkg::KIND_PRINT);
  assign res.result_value    = (kind == rpn_pkg::KIND_PRINT) ? b : 32'sd0;
  assign res.underflow       = f_under;
  assign res.stack_full      = f_full;
  assign res.zero_divisor    = f_zdiv;
  assign res.unknown_command = (kind == rpn_pkg::KIND_UNKNOWN);
  assign res.saturated       = f_sat;

endmodule

// ===== tb/rpn_stack_calculator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_checker
// Watches the command and result channels, keeps its own copy of the value
// stack, predicts the result of each command and compares every field of
// each result transfer in order.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_checker (
  input  logic      clk,
  input  logic      rst,
  rpn_cmd_if        cmd,
  rpn_res_if        res,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic               printed;
    logic signed [31:0] result_value;
    logic               underflow;
    logic               stack_full;
    logic               zero_divisor;
    logic               unknown_command;
    logic               saturated;
  } calc_result_t;

  logic signed [31:0] model_stack [rpn_pkg::STACK_DEPTH];
  int                 model_count;
  calc_result_t       expected_results [$];

  function automatic logic signed [31:0] pop_model(ref calc_result_t r);
    if (model_count > 0) begin
      model_count--;
      return model_stack[model_count];
    end
    r.underflow = 1'b1;
    return '0;
  endfunction

  function automatic void push_model(logic signed [31:0] v, ref calc_result_t r);
    if (model_count < rpn_pkg::STACK_DEPTH) begin
      model_stack[model_count] = v;
      model_count++;
    end else begin
      r.stack_full = 1'b1;
    end
  endfunction

  function automatic logic signed [31:0] clamp_wide(longint v, ref calc_result_t r);
    if (v > 64'sd2147483647) begin
      r.saturated = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      r.saturated = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic calc_result_t compute_command(rpn_pkg::kind_t kind,
                                                   logic signed [31:0] operand);
    calc_result_t r;
    longint a, b;
    logic [63:0] ma, mb, q;
    logic neg;
    r = '0;
    case (kind)
      rpn_pkg::KIND_PUSH: push_model(operand, r);
      rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL: begin
        b = pop_model(r);
        a = pop_model(r);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        if (kind == rpn_pkg::KIND_ADD) begin
          push_model(clamp_wide(a + b, r), r);
        end else if (kind == rpn_pkg::KIND_SUB) begin
          push_model(clamp_wide(a - b, r), r);
        end else begin
          q = (ma * mb) >> 16;
          push_model(clamp_wide(neg ? -$signed(q) : $signed(q), r), r);
        end
      end
      rpn_pkg::KIND_DIV, rpn_pkg::KIND_REM: begin
        b = pop_model(r);
        if (b == 0) begin
          r.zero_divisor = 1'b1;
        end else begin
          a = pop_model(r);
          ma = (a < 0) ? -a : a;
          mb = (b < 0) ? -b : b;
          neg = (a < 0) != (b < 0);
          if (kind == rpn_pkg::KIND_DIV) begin
            q = (ma << 16) / mb;
            push_model(clamp_wide(neg ? -$signed(q) : $signed(q), r), r);
          end else begin
            q = ma % mb;
            push_model((a < 0) ? -q[31:0] : q[31:0], r);
          end
        end
      end
      rpn_pkg::KIND_PRINT: begin
        r.printed = 1'b1;
        r.result_value = pop_model(r);
      end
      default: r.unknown_command = 1'b1;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    calc_result_t got, want;
    if (rst) begin
      model_count = 0;
      fail_count  <= 0;
      pending     <= 0;
      expected_results.delete();
    end else begin
      if (cmd.valid && cmd.ready)
        expected_results.push_back(compute_command(rpn_pkg::kind_t'(cmd.kind),
                                                   cmd.operand_value));
      if (res.valid && res.ready) begin
        got = {res.printed, res.result_value, res.underflow, res.stack_full,
               res.zero_divisor, res.unknown_command, res.saturated};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected p=%b v=%h u=%b f=%b z=%b k=%b s=%b",
                     $time, want.printed, want.result_value, want.underflow,
                     want.stack_full, want.zero_divisor, want.unknown_command,
                     want.saturated);
            $display("%0t:          actual p=%b v=%h u=%b f=%b z=%b k=%b s=%b",
                     $time, got.printed, got.result_value, got.underflow,
                     got.stack_full, got.zero_divisor, got.unknown_command,
                     got.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives command sequences into the calculator in bursts with gaps, stalls
// the result side on its own pattern, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;

  rpn_cmd_if cmd ();
  rpn_res_if res ();

  always #5 clk = ~clk;

  rpn_stack_calculator u_dut (.clk(clk), .rst(rst), .cmd(cmd), .res(res));

  rpn_stack_calculator_checker u_checker (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res),
    .fail_count(fail_count), .pending(pending)
  );

  int burst_left = 0;
  int gap_left   = 0;

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 255)) - 128;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_command(rpn_pkg::kind_t kind, logic signed [31:0] value);
    while (gap_left > 0) begin
      cmd.valid <= 1'b0;
      gap_left--;
      @(posedge clk);
    end
    cmd.valid         <= 1'b1;
    cmd.kind          <= kind;
    cmd.operand_value <= value;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 15))
        0, 1, 2: res.ready <= 1'b0;
        default: res.ready <= 1'b1;
      endcase
    end
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n, wait_cycles;
    cmd.valid         <= 1'b0;
    cmd.kind          <= rpn_pkg::KIND_PUSH;
    cmd.operand_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // underflow on every popping command, then unknown
    send_command(rpn_pkg::KIND_PRINT, 0);
    send_command(rpn_pkg::KIND_ADD, 0);
    send_command(rpn_pkg::KIND_SUB, 0);
    send_command(rpn_pkg::KIND_MUL, 0);
    send_command(rpn_pkg::KIND_DIV, 0);
    send_command(rpn_pkg::KIND_REM, 0);
    send_command(rpn_pkg::KIND_UNKNOWN, 32'sh7fffffff);
    send_command(rpn_pkg::KIND_PUSH, 32'sh7fffffff);
    send_command(rpn_pkg::KIND_PUSH, 32'sh7fffffff);
    send_command(rpn_pkg::KIND_ADD, 0);
    send_command(rpn_pkg::KIND_PUSH, 32'sh80000000);
    send_command(rpn_pkg::KIND_SUB, 0);
    send_command(rpn_pkg::KIND_PUSH, 32'sh80000000);
    send_command(rpn_pkg::KIND_MUL, 0);
    send_command(rpn_pkg::KIND_PUSH, -32'sh30000);
    send_command(rpn_pkg::KIND_PUSH, 32'sh20000);
    send_command(rpn_pkg::KIND_DIV, 0);
    send_command(rpn_pkg::KIND_PUSH, -32'sh70000);
    send_command(rpn_pkg::KIND_PUSH, 32'sh20000);
    send_command(rpn_pkg::KIND_REM, 0);
    send_command(rpn_pkg::KIND_PUSH, 0);
    send_command(rpn_pkg::KIND_DIV, 0);
    send_command(rpn_pkg::KIND_PRINT, 0);
    send_command(rpn_pkg::KIND_PRINT, 0);

    // fill past the top
    for (int i = 0; i < rpn_pkg::STACK_DEPTH + 3; i++)
      send_command(rpn_pkg::KIND_PUSH, pick_value());
    send_command(rpn_pkg::KIND_PUSH, 32'sh10000);
    send_command(rpn_pkg::KIND_DIV, 0);
    for (int i = 0; i < rpn_pkg::STACK_DEPTH + 2; i++)
      send_command(rpn_pkg::KIND_PRINT, 0);

    // random expressions, mostly well formed
    n = 0;
    while (n < 1000) begin
      if ($urandom_range(0, 9) == 0) begin
        send_command(rpn_pkg::kind_t'($urandom_range(0, 7)), $signed($urandom()));
        n++;
      end else begin
        send_command(rpn_pkg::KIND_PUSH, pick_value());
        send_command(rpn_pkg::KIND_PUSH, pick_value());
        send_command(rpn_pkg::kind_t'($urandom_range(rpn_pkg::KIND_ADD,
                                                     rpn_pkg::KIND_REM)),
                     $signed($urandom()));
        n += 3;
        if ($urandom_range(0, 2) == 0) begin
          send_command(rpn_pkg::KIND_PRINT, 0);
          n++;
        end
      end
    end
    cmd.valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
